// ===== design/hqs_pkg.sv =====
// Package for the quicksort engine: sequencer states and span depth width.
// No dependencies.
package hqs_pkg;

   typedef enum logic [13:0] {
      ST_LOAD   = 14'b00000000000001,
      ST_POP    = 14'b00000000000010,
      ST_PIVRD  = 14'b00000000000100,
      ST_PIVWT  = 14'b00000000001000,
      ST_IRD    = 14'b00000000010000,
      ST_IWT    = 14'b00000000100000,
      ST_JRD    = 14'b00000001000000,
      ST_JWT    = 14'b00000010000000,
      ST_SWAPI  = 14'b00000100000000,
      ST_SWAPJ  = 14'b00001000000000,
      ST_PUSHR  = 14'b00010000000000,
      ST_PUSHL  = 14'b00100000000000,
      ST_OUTRD  = 14'b01000000000000,
      ST_OUT    = 14'b10000000000000
   } state_type;

   localparam int DEPTH_W = 7;

endpackage

// ===== design/hoare_quicksort_engine.sv =====
// Hoare quicksort engine: loads a set, sorts it in its element memory, emits it.
// Uses hqs_pkg for state codes.
//
// Usage
//   req_valid/req_stall carries elements (req_value, req_last). Elements are
//   accepted one per cycle while loading; req_last starts the sort. Elements
//   beyond MAX_ITEMS are dropped and rsp_overflow is raised for that set.
//   While sorting and emitting, req_stall is high.
//   rsp_valid/rsp_stall returns the sorted set in ascending order, rsp_last_res
//   on the final element, with rsp_call_count and rsp_max_depth of the sort.
//   Each partition call reads the pivot and waits for it, pushes right, pushes
//   left and pops; each element compared is read and then waited for, and each
//   swap writes both elements, all through the one element memory. Each
//   emitted element is read, then presented.
//   While the receiver stalls, the current result holds and the sequencer
//   waits. Reset (synchronous, active high) returns to loading with an empty
//   set and cleared counters; the memories hold no reset value.
module hoare_quicksort_engine #(
   parameter int MAX_ITEMS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_value,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_value_res,
   output logic                rsp_last_res,
   output logic [6:0]          rsp_call_count,
   output logic [6:0]          rsp_max_depth,
   output logic                rsp_overflow
);

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SW = $clog2(MAX_ITEMS + 1);
   localparam int DW = hqs_pkg::DEPTH_W;

   typedef struct packed {
      logic [IW-1:0] lo;
      logic [IW-1:0] hi;
      logic [DW-1:0] depth;
   } span_type;

   logic [31:0]    mem [MAX_ITEMS];
   span_type       stk [MAX_ITEMS];

   hqs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [SW-1:0]  top_ff, top_in;
   logic [DW-1:0]  calls_ff, calls_in, peak_ff, peak_in;
   logic           drop_ff, drop_in;
   span_type       cur_ff, cur_in;
   logic [IW:0]    i_ff, i_in;
   logic signed [IW+1:0] j_ff, j_in;
   logic [31:0]    piv_ff, piv_in, vi_ff, vi_in;
   logic [IW-1:0]  k_ff, k_in;

   logic           mem_we;
   logic [IW-1:0]  mem_wa, mem_ra;
   logic [31:0]    mem_wd, mem_rd;
   logic           stk_we;
   logic [SW-1:0]  stk_wa;
   logic [IW-1:0]  stk_ra;
   span_type       stk_wd, stk_rd;

   logic           rv_ff, rv_in;
   logic [31:0]    rval_ff, rval_in;
   logic           rlast_ff, rlast_in;

   logic req_acc, rsp_acc;
   logic [IW:0] mid;
   logic signed [IW+1:0] lo_s, hi_s;
   logic [IW-1:0] j_idx;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rv_ff && !rsp_stall;
   assign req_stall = (state_ff != hqs_pkg::ST_LOAD);
   assign mid = ({1'b0, cur_ff.lo} + {1'b0, cur_ff.hi}) >> 1;
   assign lo_s = (IW+2)'({2'b00, cur_ff.lo});
   assign hi_s = (IW+2)'({2'b00, cur_ff.hi});
   assign j_idx = j_ff[IW-1:0];
   assign stk_ra = IW'(top_in - 1'b1);

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd <= mem[mem_ra];
      if (stk_we) stk[stk_wa[IW-1:0]] <= stk_wd;
      if (stk_we && stk_wa[IW-1:0] == stk_ra) stk_rd <= stk_wd;
      else stk_rd <= stk[stk_ra];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      top_in   = top_ff;
      calls_in = calls_ff;
      peak_in  = peak_ff;
      drop_in  = drop_ff;
      cur_in   = cur_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      piv_in   = piv_ff;
      vi_in    = vi_ff;
      k_in     = k_ff;
      mem_we   = 1'b0;
      mem_wa   = count_ff[IW-1:0];
      mem_wd   = {~req_value[31], req_value[30:0]};
      mem_ra   = i_ff[IW-1:0];
      stk_we   = 1'b0;
      stk_wa   = top_ff;
      stk_wd   = cur_ff;
      rv_in    = rv_ff && rsp_stall;
      rval_in  = rval_ff;
      rlast_in = rlast_ff;
      unique case (state_ff)
         hqs_pkg::ST_LOAD: begin
            if (req_acc) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last) begin
                  cur_in.lo    = '0;
                  cur_in.hi    = IW'(count_in - 1'b1);
                  cur_in.depth = DW'(1);
                  calls_in     = DW'(1);
                  peak_in      = DW'(1);
                  state_in     = hqs_pkg::ST_PIVRD;
               end
            end
         end
         hqs_pkg::ST_POP: begin
            if (top_ff == '0) begin
               k_in     = '0;
               state_in = hqs_pkg::ST_OUTRD;
            end else begin
               cur_in   = stk_rd;
               top_in   = top_ff - 1'b1;
               calls_in = calls_ff + 1'b1;
               if (stk_rd.depth > peak_ff) peak_in = stk_rd.depth;
               state_in = hqs_pkg::ST_PIVRD;
            end
         end
         hqs_pkg::ST_PIVRD: begin
            mem_ra   = mid[IW-1:0];
            i_in     = {1'b0, cur_ff.lo};
            j_in     = hi_s;
            state_in = hqs_pkg::ST_PIVWT;
         end
         hqs_pkg::ST_PIVWT: begin
            piv_in   = mem_rd;
            state_in = hqs_pkg::ST_IRD;
         end
         hqs_pkg::ST_IRD: begin
            mem_ra   = i_ff[IW-1:0];
            state_in = hqs_pkg::ST_IWT;
         end
         hqs_pkg::ST_IWT: begin
            if (mem_rd < piv_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = hqs_pkg::ST_IRD;
            end else begin
               vi_in    = mem_rd;
               state_in = hqs_pkg::ST_JRD;
            end
         end
         hqs_pkg::ST_JRD: begin
            mem_ra   = j_idx;
            state_in = hqs_pkg::ST_JWT;
         end
         hqs_pkg::ST_JWT: begin
            mem_ra = j_idx;
            if (piv_ff < mem_rd) begin
               j_in     = j_ff - 1'b1;
               state_in = hqs_pkg::ST_JRD;
            end else if ($signed({1'b0, i_ff}) <= j_ff) begin
               state_in = hqs_pkg::ST_SWAPI;
            end else begin
               state_in = hqs_pkg::ST_PUSHR;
            end
         end
         hqs_pkg::ST_SWAPI: begin
            mem_we   = 1'b1;
            mem_wa   = i_ff[IW-1:0];
            mem_wd   = mem_rd;
            state_in = hqs_pkg::ST_SWAPJ;
         end
         hqs_pkg::ST_SWAPJ: begin
            mem_we = 1'b1;
            mem_wa = j_idx;
            mem_wd = vi_ff;
            i_in   = i_ff + 1'b1;
            j_in   = j_ff - 1'b1;
            if ($signed({1'b0, i_in}) <= j_in) state_in = hqs_pkg::ST_IRD;
            else state_in = hqs_pkg::ST_PUSHR;
         end
         hqs_pkg::ST_PUSHR: begin
            if ($signed({1'b0, i_ff}) < hi_s && top_ff < SW'(MAX_ITEMS)) begin
               stk_we       = 1'b1;
               stk_wd.lo    = i_ff[IW-1:0];
               stk_wd.hi    = cur_ff.hi;
               stk_wd.depth = cur_ff.depth + 1'b1;
               top_in       = top_ff + 1'b1;
            end
            state_in = hqs_pkg::ST_PUSHL;
         end
         hqs_pkg::ST_PUSHL: begin
            if (lo_s < j_ff && top_ff < SW'(MAX_ITEMS)) begin
               stk_we       = 1'b1;
               stk_wd.lo    = cur_ff.lo;
               stk_wd.hi    = j_idx;
               stk_wd.depth = cur_ff.depth + 1'b1;
               top_in       = top_ff + 1'b1;
            end
            state_in = hqs_pkg::ST_POP;
         end
         hqs_pkg::ST_OUTRD: begin
            mem_ra = k_ff;
            if (!rv_ff || !rsp_stall) state_in = hqs_pkg::ST_OUT;
         end
         hqs_pkg::ST_OUT: begin
            rv_in    = 1'b1;
            rval_in  = {~mem_rd[31], mem_rd[30:0]};
            rlast_in = (k_ff == IW'(count_ff - 1'b1));
            if (rlast_in) begin
               state_in = hqs_pkg::ST_LOAD;
               count_in = '0;
               drop_in  = 1'b0;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = hqs_pkg::ST_OUTRD;
            end
         end
         default: state_in = hqs_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hqs_pkg::ST_LOAD;
         count_ff <= '0;
         top_ff   <= '0;
         calls_ff <= '0;
         peak_ff  <= '0;
         drop_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         calls_ff <= calls_in;
         peak_ff  <= peak_in;
         drop_ff  <= drop_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      piv_ff   <= piv_in;
      vi_ff    <= vi_in;
      k_ff     <= k_in;
      rval_ff  <= rval_in;
      rlast_ff <= rlast_in;
      if (state_ff == hqs_pkg::ST_OUT) begin
         rsp_call_count <= calls_ff;
         rsp_max_depth  <= peak_ff;
         rsp_overflow   <= drop_ff;
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_value_res = rval_ff;
   assign rsp_last_res  = rlast_ff;

endmodule

// ===== design/hqs_checker.sv =====
// Port-level checker for the quicksort engine, bound to the top level.
// Depends on hoare_quicksort_engine ports only.
module hqs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_value_res,
   input logic        rsp_last_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_res))
      else $error("stalled response changed");

   a_no_load_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_res |-> req_stall)
      else $error("input accepted during output");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_res |=> !rsp_valid)
      else $error("response after last");

endmodule

bind hoare_quicksort_engine hqs_checker u_hqs_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_value_res(rsp_value_res), .rsp_last_res(rsp_last_res)
);

// ===== dv/hoare_quicksort_engine_checker.sv =====
// Checker for the quicksort engine: watches both channels, predicts sorted sets.
// Depends on the hoare_quicksort_engine port list only.
`timescale 1ns / 1ps

module hoare_quicksort_engine_checker #(
   parameter int MAX_ITEMS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_value,
   input  logic               req_last,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_value_res,
   input  logic               rsp_last_res,
   input  logic [6:0]         rsp_call_count,
   input  logic [6:0]         rsp_max_depth,
   input  logic               rsp_overflow,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
      logic [6:0]         calls;
      logic [6:0]         depth;
      logic               overflow;
   } sorted_elem_type;

   sorted_elem_type    sorted_q[$];
   logic signed [31:0] set_buf[MAX_ITEMS];
   int                 set_len;
   logic               set_dropped;

   initial pending_count = 0;

   task automatic hoare_sort(output logic [6:0] calls, output logic [6:0] peak);
      int lo_s[$], hi_s[$], dp_s[$];
      int lo, hi, dp, i, j;
      logic signed [31:0] pivot, t;
      calls = 0;
      peak = 0;
      lo_s.push_back(0); hi_s.push_back(set_len - 1); dp_s.push_back(1);
      while (lo_s.size() > 0) begin
         lo = lo_s.pop_back(); hi = hi_s.pop_back(); dp = dp_s.pop_back();
         calls = calls + 1;
         if (dp > peak) peak = dp;
         i = lo; j = hi;
         pivot = set_buf[(lo + hi) / 2];
         do begin
            while (i <= hi && set_buf[i] < pivot) i++;
            while (j >= lo && pivot < set_buf[j]) j--;
            if (i <= j) begin
               t = set_buf[i]; set_buf[i] = set_buf[j]; set_buf[j] = t;
               i++; j--;
            end
         end while (i <= j);
         if (i < hi && lo_s.size() < MAX_ITEMS) begin
            lo_s.push_back(i); hi_s.push_back(hi); dp_s.push_back(dp + 1);
         end
         if (lo < j && lo_s.size() < MAX_ITEMS) begin
            lo_s.push_back(lo); hi_s.push_back(j); dp_s.push_back(dp + 1);
         end
      end
   endtask

   always @(posedge clock) begin
      sorted_elem_type exp_e;
      logic [6:0]      calls, peak;
      if (reset) begin
         fail_count <= 0;
         set_len = 0;
         set_dropped = 0;
         sorted_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (set_len < MAX_ITEMS) begin
               set_buf[set_len] = req_value;
               set_len++;
            end else begin
               set_dropped = 1;
            end
            if (req_last) begin
               hoare_sort(calls, peak);
               for (int k = 0; k < set_len; k++)
                  sorted_q.push_back('{set_buf[k], k == set_len - 1, calls, peak,
                                       set_dropped});
               set_len = 0;
               set_dropped = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (sorted_q.size() == 0) begin
               $error("unexpected result transaction value=%0d", rsp_value_res);
               fail_count <= fail_count + 1;
            end else begin
               exp_e = sorted_q.pop_front();
               if (exp_e.value !== rsp_value_res ||
                   exp_e.last !== rsp_last_res ||
                   exp_e.calls !== rsp_call_count ||
                   exp_e.depth !== rsp_max_depth ||
                   exp_e.overflow !== rsp_overflow)
                  fail_count <= fail_count + 1;
               if (exp_e.value !== rsp_value_res)
                  $error("value_res expected %0d got %0d", exp_e.value, rsp_value_res);
               if (exp_e.last !== rsp_last_res)
                  $error("last_res expected %0d got %0d", exp_e.last, rsp_last_res);
               if (exp_e.calls !== rsp_call_count)
                  $error("call_count expected %0d got %0d", exp_e.calls, rsp_call_count);
               if (exp_e.depth !== rsp_max_depth)
                  $error("max_depth expected %0d got %0d", exp_e.depth, rsp_max_depth);
               if (exp_e.overflow !== rsp_overflow)
                  $error("overflow expected %0d got %0d", exp_e.overflow, rsp_overflow);
            end
         end
      end
      pending_count = sorted_q.size();
   end

endmodule

// ===== dv/hoare_quicksort_engine_test.sv =====
// Testbench top for the quicksort engine: clock, reset, set stimulus, verdict.
// Depends on hoare_quicksort_engine and hoare_quicksort_engine_checker.
`timescale 1ns / 1ps

module hoare_quicksort_engine_test;

   localparam int MAX_ITEMS = 16;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [31:0] req_value = 0;
   logic               req_last = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [31:0] rsp_value_res;
   logic               rsp_last_res;
   logic [6:0]         rsp_call_count;
   logic [6:0]         rsp_max_depth;
   logic               rsp_overflow;
   int                 fail_count;
   int                 pending_count;
   int                 send_idle_pct;
   int                 recv_idle_pct;

   hoare_quicksort_engine #(.MAX_ITEMS(MAX_ITEMS)) u_top (.*);

   hoare_quicksort_engine_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_elem(input logic signed [31:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_value <= value;
      req_last  <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 0;
   endtask

   function automatic logic signed [31:0] rand_value(input int mode);
      case (mode)
         0: return $urandom_range(7) - 4;
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_set(input int len, input int mode);
      for (int k = 0; k < len; k++)
         send_elem(rand_value(mode), k == len - 1);
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_elem(32'sh7fffffff, 1);
      send_elem(32'sh80000000, 0);
      send_elem(32'sh7fffffff, 0);
      send_elem(-1, 0);
      send_elem(0, 1);
      for (int k = 0; k < MAX_ITEMS; k++) send_elem(k, k == MAX_ITEMS - 1);
      send_set(MAX_ITEMS + 3, 2);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 75 : 0;
         recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 14 : 0;
         for (int s = 0; s < 4; s++) begin
            send_set($urandom_range(1, MAX_ITEMS + 2), $urandom_range(2));
            if (s == 1) wait (pending_count == 0);
         end
      end
      wait (pending_count == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
